/* hdl/hpa_pkg.sv */
// ----------------------------------------------------------------------------
// hpa_pkg: shared types and constants for the handle pool allocator
// Opcode and status codes, handle widths and the fresh-handle limit.
// ----------------------------------------------------------------------------
package hpa_pkg;

   localparam int POOL_SIZE    = 256;
   localparam int HANDLE_SPACE = 256;
   localparam int HANDLE_W     = 8;
   localparam int COUNT_W      = 9;
   // fresh handles stop at the smaller of the pool size and the handle space
   localparam int POOL_LIMIT   = (POOL_SIZE > HANDLE_SPACE) ? HANDLE_SPACE : POOL_SIZE;

   typedef enum logic [1:0] {
      OP_ALLOC     = 2'd0,
      OP_TRY_ALLOC = 2'd1,
      OP_FREE      = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [COUNT_W-1:0]  count_type;

endpackage

/* hdl/handle_pool_allocator_unit.sv */
// ----------------------------------------------------------------------------
// handle_pool_allocator_unit: handle pool with a FIFO free list
// Allocates, try-allocates and frees 8-bit handles, one request per cycle while results drain.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata               | tuser
//  --------+-----------+---------------------+-------------
//  req_    | in        | [7:0] handle_in     | [1:0] opcode
//  rsp_    | out       | [7:0] handle_out    | [1:0] status
//
//  A result passes the input register, then the result register, before it
//  is offered; one request per cycle is sustained while results drain, set by
//  the combinational bitmap lookup and the prefetching free-list read port.
//  Reset needs no clearing pass: the bitmap is cleared flip-flops and the
//  free list is tracked by head, tail and count.
//  A stalled result holds; one more request waits in the input register.
//
module handle_pool_allocator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] handle_in
   input  logic [1:0]            req_tuser,   // [1:0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] handle_out
   output logic [1:0]            rsp_tuser    // [1:0] status
);
   import hpa_pkg::*;

   // input register
   logic        in_valid_ff;
   op_type      in_op_ff;
   handle_type  in_handle_ff;

   // result register
   logic        rsp_valid_ff;
   handle_type  rsp_handle_ff;
   status_type  rsp_status_ff;

   // pool state
   handle_type               head_ff, head_in;
   handle_type               tail_ff, tail_in;
   count_type                count_ff, count_in;
   count_type                fresh_ff, fresh_in;
   logic [HANDLE_SPACE-1:0]  in_use_ff, in_use_in;

   // free-list memory and its read-bypass
   handle_type  free_mem [HANDLE_SPACE];
   handle_type  mem_rd_ff;
   logic        byp_hit_ff;
   handle_type  byp_data_ff;
   logic        mem_we;
   handle_type  head_val;

   logic        advance;
   logic        out_free;
   handle_type  res_handle;
   status_type  res_status;

   // a result moves on when the result register is empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // the head entry: last cycle's write wins if it hit the prefetched address
   assign head_val = byp_hit_ff ? byp_data_ff : mem_rd_ff;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      fresh_in   = fresh_ff;
      in_use_in  = in_use_ff;
      mem_we     = 1'b0;
      res_handle = '0;
      res_status = ST_OK;
      if (advance) begin
         unique case (in_op_ff)
            OP_ALLOC, OP_TRY_ALLOC: begin
               if (count_ff != '0) begin
                  // reuse the oldest freed handle
                  res_handle           = head_val;
                  in_use_in[head_val]  = 1'b1;
                  head_in              = head_ff + 1'b1;
                  count_in             = count_ff - 1'b1;
               end else if (in_op_ff == OP_TRY_ALLOC) begin
                  res_status = ST_NONE;
               end else if (fresh_ff < COUNT_W'(POOL_LIMIT)) begin
                  res_handle                         = fresh_ff[HANDLE_W-1:0];
                  in_use_in[fresh_ff[HANDLE_W-1:0]]  = 1'b1;
                  fresh_in                           = fresh_ff + 1'b1;
               end else begin
                  res_status = ST_EXHAUSTED;
               end
            end
            OP_FREE: begin
               // a free onto a full list cannot occur, but is rejected as a guard
               if (!in_use_ff[in_handle_ff] || count_ff[COUNT_W-1]) begin
                  res_status = ST_NOT_ALLOC;
               end else begin
                  in_use_in[in_handle_ff] = 1'b0;
                  mem_we                  = 1'b1;
                  tail_in                 = tail_ff + 1'b1;
                  count_in                = count_ff + 1'b1;
               end
            end
            OP_NOP: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   // free-list storage; the read port always fetches the next head entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_mem[tail_ff] <= in_handle_ff;
      end
      mem_rd_ff   <= free_mem[head_in];
      byp_data_ff <= in_handle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= mem_we && (tail_ff == head_in);
      end
   end

   // control and pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         in_use_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         fresh_ff  <= fresh_in;
         in_use_ff <= in_use_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff     <= op_type'(req_tuser);
         in_handle_ff <= req_tdata;
      end
      if (advance) begin
         rsp_handle_ff <= res_handle;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* hdl/hpa_checker.sv */
// ----------------------------------------------------------------------------
// hpa_checker: port-level checks for the handle pool allocator
// Watches the request and result channels and flags unexpected behavior.
// ----------------------------------------------------------------------------
module hpa_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic [1:0] req_tuser,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [1:0] rsp_tuser
);
   import hpa_pkg::*;

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a handle is only given out with an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != 8'd0) |-> rsp_tuser == ST_OK)
      else $error("nonzero handle with error status");

   // every new result follows a request transfer through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a request");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind handle_pool_allocator_unit hpa_checker u_hpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* dv/tb_handle_pool_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_pool_allocator_unit: self-checking bench for the handle pool
// Drives a directed table and then about 1550 random requests through the
// req_ stream. An in-bench predictor tracks the in-use map, the free list and
// the fresh-handle counter. Each rsp_ transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_handle_pool_allocator_unit;
   import hpa_pkg::*;

   localparam int RANDOM_REQUESTS = 1550;
   localparam int PHASE_LEN       = 250;   // random requests per fill/drain phase
   localparam int HOLD_OFF_CYCLES = 64;    // long receiver stall, well past the 2-deep pipe
   localparam int SETTLE_CYCLES   = 8;     // settle time after the last result has come back

   // one result transfer: handle_out in tdata, status in tuser
   typedef struct packed {
      handle_type handle;
      status_type status;
   } pool_result;

   // directed stimulus row; exp_* only used when typed is set
   typedef struct {
      op_type     op;
      handle_type handle;
      bit         typed;
      handle_type exp_handle;
      status_type exp_status;
   } directed_row;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] handle_in
   logic [1:0] req_tuser;    // [1:0] opcode
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] handle_out
   logic [1:0] rsp_tuser;    // [1:0] status

   // predictor state: a mirror of the pool as seen by accepted requests
   bit [HANDLE_SPACE-1:0] pool_in_use;
   handle_type            recycled_handles[$];   // free list, oldest at index 0
   int                    fresh_count;

   // expected results, oldest first, queued when a request transfer happens
   pool_result pending_responses[$];

   int  error_count;
   int  result_count;
   int  op_count[4];
   int  status_count[4];
   int  long_holds;
   bit  calm_stretch;     // when set, neither side idles
   bit  stall_request;    // stimulus asks the receiver for one long hold-off

   handle_pool_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table. Fresh handles come out in order 0,1,2,...; freed handles
   // are reused oldest first. Rows with typed=0 are left to the predictor.
   directed_row directed_rows [24] = '{
      '{OP_TRY_ALLOC, 8'd0,   1'b1, 8'd0, ST_NONE     },  // empty list after reset
      '{OP_FREE,      8'd0,   1'b1, 8'd0, ST_NOT_ALLOC},  // never issued
      '{OP_FREE,      8'd255, 1'b1, 8'd0, ST_NOT_ALLOC},  // top handle, never issued
      '{OP_NOP,       8'd255, 1'b1, 8'd0, ST_OK       },  // no-op opcode
      '{OP_ALLOC,     8'd255, 1'b1, 8'd0, ST_OK       },  // handle_in ignored
      '{OP_ALLOC,     8'd0,   1'b1, 8'd1, ST_OK       },
      '{OP_ALLOC,     8'd0,   1'b1, 8'd2, ST_OK       },
      '{OP_FREE,      8'd1,   1'b1, 8'd0, ST_OK       },
      '{OP_FREE,      8'd1,   1'b1, 8'd0, ST_NOT_ALLOC},  // double free
      '{OP_FREE,      8'd0,   1'b1, 8'd0, ST_OK       },
      '{OP_TRY_ALLOC, 8'd0,   1'b1, 8'd1, ST_OK       },  // oldest freed first
      '{OP_ALLOC,     8'd0,   1'b1, 8'd0, ST_OK       },  // reuse before fresh
      '{OP_TRY_ALLOC, 8'd0,   1'b1, 8'd0, ST_NONE     },  // fresh left, still none
      '{OP_ALLOC,     8'd0,   1'b1, 8'd3, ST_OK       },
      '{OP_FREE,      8'd2,   1'b1, 8'd0, ST_OK       },
      '{OP_FREE,      8'd3,   1'b1, 8'd0, ST_OK       },
      '{OP_FREE,      8'd0,   1'b1, 8'd0, ST_OK       },
      '{OP_ALLOC,     8'd0,   1'b0, 8'd0, ST_OK       },
      '{OP_TRY_ALLOC, 8'd0,   1'b0, 8'd0, ST_OK       },
      '{OP_ALLOC,     8'd0,   1'b0, 8'd0, ST_OK       },
      '{OP_ALLOC,     8'd0,   1'b0, 8'd0, ST_OK       },
      '{OP_FREE,      8'd170, 1'b1, 8'd0, ST_NOT_ALLOC},  // alternating bits, never issued
      '{OP_NOP,       8'd0,   1'b1, 8'd0, ST_OK       },
      '{OP_FREE,      8'd4,   1'b1, 8'd0, ST_OK       }
   };

   // Predictor: apply one accepted request to the mirror and return its result.
   function automatic pool_result predict_pool_response(input op_type op,
                                                        input handle_type hin);
      pool_result r;
      r.handle = '0;
      r.status = ST_OK;
      case (op)
         OP_ALLOC, OP_TRY_ALLOC: begin
            if (recycled_handles.size() > 0) begin
               r.handle = recycled_handles[0];
               recycled_handles.delete(0);
               pool_in_use[r.handle] = 1'b1;
            end else if (op == OP_TRY_ALLOC) begin
               r.status = ST_NONE;
            end else if (fresh_count < POOL_LIMIT) begin
               r.handle = handle_type'(fresh_count);
               pool_in_use[r.handle] = 1'b1;
               fresh_count++;
            end else begin
               r.status = ST_EXHAUSTED;
            end
         end
         OP_FREE: begin
            // guard on a full list can't trigger, kept to mirror the block
            if (!pool_in_use[hin] || recycled_handles.size() >= HANDLE_SPACE) begin
               r.status = ST_NOT_ALLOC;
            end else begin
               pool_in_use[hin] = 1'b0;
               recycled_handles.insert(recycled_handles.size(), hin);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // First allocated handle at or after start (wrapping); start if none.
   function automatic handle_type pick_in_use(input handle_type start);
      handle_type probe;
      for (int i = 0; i < HANDLE_SPACE; i++) begin
         probe = start + handle_type'(i);
         if (pool_in_use[probe]) return probe;
      end
      return start;
   endfunction

   // Offer one request, hold it until the transfer, then record the expectation.
   task automatic send_request(input op_type op, input handle_type hin,
                               input bit typed, input pool_result typed_result);
      pool_result predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= hin;
      do @(posedge clock); while (!req_tready);
      predicted = predict_pool_response(op, hin);
      if (typed) predicted = typed_result;
      pending_responses.insert(pending_responses.size(), predicted);
      op_count[op]++;
      status_count[predicted.status]++;
   endtask

   // Random sender gap, about one request in four, skipped in the calm stretch.
   task automatic sender_gap();
      if (!calm_stretch && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // Stop offering until every expected result has come back.
   task automatic drain_pool_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Fill phases lean on allocates so the fresh counter runs out and
   // exhaustion shows up; drain phases lean on frees of live handles so the
   // free list grows and wraps. Bad frees and no-ops are sprinkled as noise.
   task automatic pick_random_request(input bit fill_mode, output op_type op,
                                      output handle_type h);
      int roll;
      roll = $urandom_range(0, 99);
      h    = handle_type'($urandom_range(0, 255));
      if (fill_mode) begin
         if      (roll < 75) op = OP_ALLOC;
         else if (roll < 85) op = OP_TRY_ALLOC;
         else if (roll < 93) begin op = OP_FREE; h = pick_in_use(h); end
         else if (roll < 97) op = OP_FREE;
         else                op = OP_NOP;
      end else begin
         if      (roll < 20) op = OP_ALLOC;
         else if (roll < 40) op = OP_TRY_ALLOC;
         else if (roll < 85) begin op = OP_FREE; h = pick_in_use(h); end
         else if (roll < 95) op = OP_FREE;
         else                op = OP_NOP;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: check each rsp_ transfer against the oldest expectation,
   // then pick tready for the next cycle (random, long hold-off, or calm).
   // ------------------------------------------------------------------------
   initial begin : result_checker
      int         hold_left;
      pool_result want;
      status_type got;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            result_count++;
            got = status_type'(rsp_tuser);
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected result, expected none, ", $time,
                        "actual handle %0d status %s", rsp_tdata, got.name());
               error_count++;
            end else begin
               want = pending_responses[0];
               pending_responses.delete(0);
               if (rsp_tdata !== want.handle) begin
                  $display("%0t: handle_out mismatch, expected %0d, actual %0d",
                           $time, want.handle, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %s, actual %s",
                           $time, want.status.name(), got.name());
                  error_count++;
               end
            end
         end
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = HOLD_OFF_CYCLES;
            long_holds++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm_stretch) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side: reset, directed table, then the random phases.
   // ------------------------------------------------------------------------
   initial begin : request_driver
      op_type     op;
      handle_type h;
      pool_result typed_result;
      error_count   = 0;
      result_count  = 0;
      fresh_count   = 0;
      pool_in_use   = '0;
      long_holds    = 0;
      calm_stretch  = 1'b0;
      stall_request = 1'b0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_ALLOC;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_result.handle = directed_rows[i].exp_handle;
         typed_result.status = directed_rows[i].exp_status;
         send_request(directed_rows[i].op, directed_rows[i].handle,
                      directed_rows[i].typed, typed_result);
         sender_gap();
      end
      drain_pool_results();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // long receiver stall while requests keep coming: the pipe fills
         // and req_tready has to drop
         if (n == 300 || n == 1100) stall_request = 1'b1;
         // stretch with no idling on either side
         calm_stretch = (n >= 500 && n < 700);
         // sender waits for the block to empty completely
         if (n == 775) drain_pool_results();
         pick_random_request(((n / PHASE_LEN) % 2) == 0, op, h);
         send_request(op, h, 1'b0, typed_result);
         sender_gap();
      end
      req_tvalid <= 1'b0;
      calm_stretch = 1'b0;

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests: ",
               op_count[OP_ALLOC] + op_count[OP_TRY_ALLOC] + op_count[OP_FREE] +
               op_count[OP_NOP],
               "%0d allocate, %0d try-allocate, %0d free, %0d no-op; ",
               op_count[OP_ALLOC], op_count[OP_TRY_ALLOC], op_count[OP_FREE],
               op_count[OP_NOP],
               "%0d results checked, %0d long stalls.", result_count, long_holds);
      $display("Statuses: %0d ok, %0d none to reuse, ",
               status_count[ST_OK], status_count[ST_NONE],
               "%0d not allocated, %0d exhausted; %0d fresh handles issued.",
               status_count[ST_NOT_ALLOC], status_count[ST_EXHAUSTED], fresh_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, pending_responses.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hpa_pkg.sv
hdl/handle_pool_allocator_unit.sv
hdl/hpa_checker.sv
dv/tb_handle_pool_allocator_unit.sv
